FILE: rtl/core/rrht_pkg.sv
package rrht_pkg;

  localparam int TRACKS      = 4;
  localparam int TRACK_DEPTH = 8;

  localparam int CAR_W  = 8;
  localparam int KIND_W = 2;
  localparam int TOUT_W = 2;
  localparam int SLOTS  = TRACKS * TRACK_DEPTH;
  localparam int TIDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int PTR_W  = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TRACK_DEPTH + 1);
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int PADDR_W = 3;
  localparam logic [CAR_W-1:0] FIRST_NUMBER_RST = 8'd1;

  typedef enum logic [KIND_W-1:0] {
    EV_FROM_INPUT = 2'd0,
    EV_FROM_TRACK = 2'd1,
    EV_HELD       = 2'd2,
    EV_FAULT      = 2'd3
  } event_kind_e;

  typedef enum logic [0:0] {
    REG_FIRST_NUMBER = 1'b0,
    REG_NONE         = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FETCH
  } state_e;

  typedef struct packed {
    logic accept;
    logic take_expected;
    logic do_place;
    logic emit_fault;
    logic drain_pop;
    logic finish;
    logic load_head;
  } cmd_t;

  typedef struct packed {
    logic fault;
    logic expected;
    logic match_any;
    logic refetch;
    logic out_free;
  } status_t;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(TRACK_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(logic [TIDX_W-1:0] t,
                                                  logic [PTR_W-1:0] p);
    int a;
    a = int'(t) * TRACK_DEPTH + int'(p);
    return ADDR_W'(a);
  endfunction

endpackage

FILE: rtl/core/rrht_ram.sv
module rrht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rrht_ctrl.sv
module rrht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rrht_pkg::status_t status_i,
  output rrht_pkg::cmd_t    cmd_o
);

  rrht_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrht_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rrht_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = rrht_pkg::ST_EVAL;
        end
      end
      rrht_pkg::ST_EVAL: begin
        if (status_i.fault) begin
          if (status_i.out_free) begin
            cmd_o.emit_fault = 1'b1;
            state_d          = rrht_pkg::ST_IDLE;
          end
        end else if (status_i.expected) begin
          cmd_o.take_expected = 1'b1;
          state_d             = rrht_pkg::ST_SCAN;
        end else if (status_i.out_free) begin
          cmd_o.do_place = 1'b1;
          state_d        = rrht_pkg::ST_IDLE;
        end
      end
      rrht_pkg::ST_SCAN: begin
        // the staged result goes out once we know whether another follows
        if (status_i.out_free) begin
          if (status_i.match_any) begin
            cmd_o.drain_pop = 1'b1;
            state_d = status_i.refetch ? rrht_pkg::ST_FETCH : rrht_pkg::ST_SCAN;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = rrht_pkg::ST_IDLE;
          end
        end
      end
      rrht_pkg::ST_FETCH: begin
        cmd_o.load_head = 1'b1;
        state_d         = rrht_pkg::ST_SCAN;
      end
      default: begin
        state_d = rrht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/rrht_dpath.sv
module rrht_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrht_pkg::cmd_t                   cmd_i,
  output rrht_pkg::status_t                status_o,
  input  logic [rrht_pkg::CAR_W-1:0]       car_number_i,
  input  logic                             cfg_we_i,
  input  logic [rrht_pkg::CAR_W-1:0]       cfg_wdata_i,
  output logic [rrht_pkg::CAR_W-1:0]       first_number_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rrht_pkg::CAR_W-1:0]       car_out_o,
  output logic [rrht_pkg::KIND_W-1:0]      event_kind_o,
  output logic [rrht_pkg::TOUT_W-1:0]      track_index_o,
  output logic                             last_o
);

  localparam int T = rrht_pkg::TRACKS;

  logic [rrht_pkg::CAR_W-1:0]  first_q, next_exp_q, car_q;
  logic                        fault_q;
  logic [rrht_pkg::PTR_W-1:0]  head_ptr_q [T];
  logic [rrht_pkg::PTR_W-1:0]  tail_ptr_q [T];
  logic [rrht_pkg::CNT_W-1:0]  cnt_q [T];
  logic [rrht_pkg::CAR_W-1:0]  head_val_q [T];
  logic [rrht_pkg::CAR_W-1:0]  tail_val_q [T];
  logic [rrht_pkg::TIDX_W-1:0] fetch_trk_q;

  logic [rrht_pkg::CAR_W-1:0]  pend_car_q;
  rrht_pkg::event_kind_e       pend_kind_q;
  logic [rrht_pkg::TOUT_W-1:0] pend_trk_q;

  logic                        out_valid_q;
  logic [rrht_pkg::CAR_W-1:0]  out_car_q;
  rrht_pkg::event_kind_e       out_kind_q;
  logic [rrht_pkg::TOUT_W-1:0] out_trk_q;
  logic                        out_last_q;

  logic [T-1:0]                match, usable;
  logic [rrht_pkg::TIDX_W-1:0] msel, usel;
  logic                        match_any, usable_any, out_free;
  logic [rrht_pkg::CAR_W-1:0]  next_exp_inc;
  logic [rrht_pkg::CAR_W-1:0]  msel_ext, usel_ext;
  logic [rrht_pkg::PTR_W-1:0]  msel_head_nxt;

  logic                        out_load;
  logic [rrht_pkg::CAR_W-1:0]  out_car_d;
  rrht_pkg::event_kind_e       out_kind_d;
  logic [rrht_pkg::TOUT_W-1:0] out_trk_d;
  logic                        out_last_d;

  logic                        ram_we;
  logic [rrht_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [rrht_pkg::CAR_W-1:0]  ram_rdata;

  assign next_exp_inc = next_exp_q + rrht_pkg::CAR_W'(1);
  assign out_free     = !out_valid_q || out_ready_i;

  // head and tail values are mirrored in flops so every track is checked at once
  always_comb begin
    for (int t = 0; t < T; t++) begin
      match[t]  = (cnt_q[t] != '0) && (head_val_q[t] == next_exp_q);
      usable[t] = (cnt_q[t] == '0) ||
                  ((cnt_q[t] < rrht_pkg::CNT_W'(rrht_pkg::TRACK_DEPTH)) &&
                   (tail_val_q[t] < car_q));
    end
  end

  always_comb begin
    msel = '0;
    usel = '0;
    for (int t = T - 1; t >= 0; t--) begin
      if (match[t]) msel = rrht_pkg::TIDX_W'(t);
      if (usable[t]) usel = rrht_pkg::TIDX_W'(t);
    end
  end

  assign match_any     = |match;
  assign usable_any    = |usable;
  assign msel_ext      = rrht_pkg::CAR_W'(msel);
  assign usel_ext      = rrht_pkg::CAR_W'(usel);
  assign msel_head_nxt = rrht_pkg::ptr_inc(head_ptr_q[msel]);

  assign status_o.fault     = fault_q;
  assign status_o.expected  = (car_q == next_exp_q);
  assign status_o.match_any = match_any;
  assign status_o.refetch   = (cnt_q[msel] != rrht_pkg::CNT_W'(1));
  assign status_o.out_free  = out_free;

  assign ram_we    = cmd_i.do_place && !fault_q && usable_any;
  assign ram_waddr = rrht_pkg::slot_addr(usel, tail_ptr_q[usel]);
  assign ram_raddr = rrht_pkg::slot_addr(msel, msel_head_nxt);

  rrht_ram #(
    .WIDTH (rrht_pkg::CAR_W),
    .DEPTH (rrht_pkg::SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (car_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_load   = 1'b0;
    out_car_d  = car_q;
    out_kind_d = rrht_pkg::EV_FAULT;
    out_trk_d  = '0;
    out_last_d = 1'b1;
    if (cmd_i.emit_fault) begin
      out_load = 1'b1;
    end else if (cmd_i.do_place) begin
      out_load = 1'b1;
      if (usable_any) begin
        out_kind_d = rrht_pkg::EV_HELD;
        out_trk_d  = usel_ext[rrht_pkg::TOUT_W-1:0];
      end
    end else if (cmd_i.drain_pop || cmd_i.finish) begin
      out_load   = 1'b1;
      out_car_d  = pend_car_q;
      out_kind_d = pend_kind_q;
      out_trk_d  = pend_trk_q;
      out_last_d = cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= rrht_pkg::FIRST_NUMBER_RST;
      next_exp_q  <= rrht_pkg::FIRST_NUMBER_RST;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int t = 0; t < T; t++) begin
        head_ptr_q[t] <= '0;
        tail_ptr_q[t] <= '0;
        cnt_q[t]      <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        first_q    <= cfg_wdata_i;
        next_exp_q <= cfg_wdata_i;
      end
      if (cmd_i.take_expected || cmd_i.drain_pop) begin
        next_exp_q <= next_exp_inc;
      end
      if (cmd_i.do_place && !fault_q) begin
        if (usable_any) begin
          tail_ptr_q[usel] <= rrht_pkg::ptr_inc(tail_ptr_q[usel]);
          cnt_q[usel]      <= cnt_q[usel] + rrht_pkg::CNT_W'(1);
        end else begin
          fault_q <= 1'b1;
        end
      end
      if (cmd_i.drain_pop) begin
        head_ptr_q[msel] <= msel_head_nxt;
        cnt_q[msel]      <= cnt_q[msel] - rrht_pkg::CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      car_q <= car_number_i;
    end
    if (cmd_i.do_place && !fault_q && usable_any) begin
      tail_val_q[usel] <= car_q;
      if (cnt_q[usel] == '0) begin
        head_val_q[usel] <= car_q;
      end
    end
    if (cmd_i.take_expected) begin
      pend_car_q  <= car_q;
      pend_kind_q <= rrht_pkg::EV_FROM_INPUT;
      pend_trk_q  <= '0;
    end
    if (cmd_i.drain_pop) begin
      pend_car_q  <= next_exp_q;
      pend_kind_q <= rrht_pkg::EV_FROM_TRACK;
      pend_trk_q  <= msel_ext[rrht_pkg::TOUT_W-1:0];
      fetch_trk_q <= msel;
    end
    if (cmd_i.load_head) begin
      head_val_q[fetch_trk_q] <= ram_rdata;
    end
    if (out_load) begin
      out_car_q  <= out_car_d;
      out_kind_q <= out_kind_d;
      out_trk_q  <= out_trk_d;
      out_last_q <= out_last_d;
    end
  end

  assign first_number_o = first_q;
  assign out_valid_o    = out_valid_q;
  assign car_out_o      = out_car_q;
  assign event_kind_o   = out_kind_q;
  assign track_index_o  = out_trk_q;
  assign last_o         = out_last_q;

endmodule

FILE: rtl/core/railcar_reorder_holding_tracks_unit.sv
// railcar reorder unit: numbered cars enter on the s_axis channel, one per
// transaction, and leave on the m_axis channel in ascending order starting at
// first_number (apb register at address 0, reset value 1; writing it also
// reloads the expected number). a car that does not match is parked on one of
// the holding tracks and reported with a held event; m_axis_tlast marks the
// final result caused by each input car.
// timing: a car that is parked or faults returns to idle after its evaluation
// step, its result registered at the end of the evaluation cycle. a car that
// matches then drains each car that follows from the tracks, with an extra fetch
// step per drained car that leaves further cars on its track, since the new
// track head is read from the track store, whose read port is registered. the
// result of each drained car is held until the next match is known.
// the input is taken only in the idle state; when m_axis_tready is low the
// unit holds its output register, and steps that load it wait until it drains.
// reset clears all tracks and the fault; a no-track fault sticks until reset,
// and every later car then gives a single fault result.
module railcar_reorder_holding_tracks_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] car_number
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] car_out
  output logic [3:0]                   m_axis_tuser,  // [1:0] event_kind, [3:2] track_index
  output logic                         m_axis_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrht_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  rrht_pkg::cmd_t              cmd;
  rrht_pkg::status_t           status;
  rrht_pkg::reg_index_e        reg_idx;
  logic                        cfg_we;
  logic [rrht_pkg::CAR_W-1:0]  first_number;
  logic [rrht_pkg::KIND_W-1:0] event_kind;
  logic [rrht_pkg::TOUT_W-1:0] track_index;

  assign pready  = 1'b1;
  assign reg_idx = rrht_pkg::reg_index_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && (reg_idx == rrht_pkg::REG_FIRST_NUMBER);

  always_comb begin
    case (reg_idx)
      rrht_pkg::REG_FIRST_NUMBER: prdata = 32'(first_number);
      default:                    prdata = '0;
    endcase
  end

  rrht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrht_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .car_number_i   (s_axis_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[rrht_pkg::CAR_W-1:0]),
    .first_number_o (first_number),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .car_out_o      (m_axis_tdata),
    .event_kind_o   (event_kind),
    .track_index_o  (track_index),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tuser = {track_index, event_kind};

endmodule

FILE: tb/sv/tb_railcar_reorder_holding_tracks_unit.sv
module tb_railcar_reorder_holding_tracks_unit;

  localparam int          IDLE_PCT     = 24;
  localparam int          RUN_LIMIT    = 400000;
  localparam int          LONG_HOLD    = 300;
  localparam int          PHASE_CARS   = 64;
  localparam int          RANDOM_PHASES = 3;
  localparam int          QUIET_FROM   = 80;
  localparam int          QUIET_TO     = 140;
  localparam int          HOLD_AT      = 170;
  localparam int          SETTLE_CYCLES = 8;
  localparam logic [rrht_pkg::PADDR_W-1:0] FIRST_NUMBER_ADDR =
    rrht_pkg::PADDR_W'(4 * rrht_pkg::REG_FIRST_NUMBER);
  localparam logic [rrht_pkg::PADDR_W-1:0] SPARE_ADDR =
    rrht_pkg::PADDR_W'(4 * rrht_pkg::REG_NONE);
  localparam logic [rrht_pkg::CAR_W-1:0] OPENING_CARS [8] = '{8'd1, 8'd3, 8'd2, 8'd6, 8'd5,
                                                              8'd4, 8'd0, 8'd255};
  localparam logic [rrht_pkg::CAR_W-1:0] FAULT_CARS [5] = '{8'd200, 8'd150, 8'd100, 8'd50,
                                                            8'd10};

  typedef struct packed {
    logic [rrht_pkg::CAR_W-1:0]  car;
    rrht_pkg::event_kind_e       kind;
    logic [rrht_pkg::TOUT_W-1:0] trk;
    logic                        last;
  } car_event_t;

  class railcar_board;
    logic [rrht_pkg::CAR_W-1:0] slot_car [rrht_pkg::SLOTS];
    int unsigned                head_pos [rrht_pkg::TRACKS];
    int unsigned                tail_pos [rrht_pkg::TRACKS];
    int unsigned                fill [rrht_pkg::TRACKS];
    logic [rrht_pkg::CAR_W-1:0] next_car;
    bit                         stuck;
    car_event_t                 due_events [$];
    int unsigned                mismatches;

    function new();
      foreach (fill[t]) begin
        head_pos[t] = 0;
        tail_pos[t] = 0;
        fill[t]     = 0;
      end
      next_car   = rrht_pkg::FIRST_NUMBER_RST;
      stuck      = 1'b0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void load_first(logic [rrht_pkg::CAR_W-1:0] value);
      next_car = value;
    endfunction

    function car_event_t make_event(logic [rrht_pkg::CAR_W-1:0] car,
                                    rrht_pkg::event_kind_e kind, int t, logic last);
      car_event_t ev;
      ev.car  = car;
      ev.kind = kind;
      ev.trk  = rrht_pkg::TOUT_W'(t);
      ev.last = last;
      return ev;
    endfunction

    function bit track_takes(int t, logic [rrht_pkg::CAR_W-1:0] car);
      logic [rrht_pkg::CAR_W-1:0] tail_car;
      if (fill[t] == 0) return 1'b1;
      tail_car = slot_car[t * rrht_pkg::TRACK_DEPTH +
                          (tail_pos[t] + rrht_pkg::TRACK_DEPTH - 1) % rrht_pkg::TRACK_DEPTH];
      return (fill[t] < rrht_pkg::TRACK_DEPTH) && (tail_car < car);
    endfunction

    function int parking_track(logic [rrht_pkg::CAR_W-1:0] car);
      for (int t = 0; t < rrht_pkg::TRACKS; t++) begin
        if (track_takes(t, car)) return t;
      end
      return -1;
    endfunction

    function bit would_fault(logic [rrht_pkg::CAR_W-1:0] car);
      return stuck || (car != next_car && parking_track(car) < 0);
    endfunction

    function int unsigned held_cars();
      int unsigned n;
      n = 0;
      foreach (fill[t]) n += fill[t];
      return n;
    endfunction

    function logic [rrht_pkg::CAR_W-1:0] first_head();
      for (int t = 0; t < rrht_pkg::TRACKS; t++) begin
        if (fill[t] != 0) return slot_car[t * rrht_pkg::TRACK_DEPTH + head_pos[t]];
      end
      return next_car;
    endfunction

    // predicts every result caused by one accepted car
    function void take_car(logic [rrht_pkg::CAR_W-1:0] car);
      car_event_t run [$];
      car_event_t ev;
      int         t;
      if (stuck) begin
        due_events.push_back(make_event(car, rrht_pkg::EV_FAULT, 0, 1'b1));
        return;
      end
      if (car == next_car) begin
        run.push_back(make_event(car, rrht_pkg::EV_FROM_INPUT, 0, 1'b0));
        next_car = next_car + 8'd1;
        t = 0;
        // rescan from track 0 after every release
        while (t < rrht_pkg::TRACKS) begin
          if (fill[t] != 0 &&
              slot_car[t * rrht_pkg::TRACK_DEPTH + head_pos[t]] == next_car) begin
            run.push_back(make_event(next_car, rrht_pkg::EV_FROM_TRACK, t, 1'b0));
            head_pos[t] = (head_pos[t] + 1) % rrht_pkg::TRACK_DEPTH;
            fill[t]--;
            next_car = next_car + 8'd1;
            t = 0;
          end else begin
            t++;
          end
        end
        ev = run.pop_back();
        ev.last = 1'b1;
        run.push_back(ev);
        foreach (run[k]) due_events.push_back(run[k]);
        return;
      end
      t = parking_track(car);
      if (t >= 0) begin
        slot_car[t * rrht_pkg::TRACK_DEPTH + tail_pos[t]] = car;
        tail_pos[t] = (tail_pos[t] + 1) % rrht_pkg::TRACK_DEPTH;
        fill[t]++;
        due_events.push_back(make_event(car, rrht_pkg::EV_HELD, t, 1'b1));
      end else begin
        stuck = 1'b1;
        due_events.push_back(make_event(car, rrht_pkg::EV_FAULT, 0, 1'b1));
      end
    endfunction

    task match_event(logic [rrht_pkg::CAR_W-1:0] car, logic [rrht_pkg::KIND_W-1:0] kind,
                     logic [rrht_pkg::TOUT_W-1:0] trk, logic last);
      car_event_t ev;
      if (due_events.size() == 0) begin
        report($sformatf("result car %0d kind %0d track %0d last %0b with none due",
                         car, kind, trk, last));
        return;
      end
      ev = due_events.pop_front();
      if (car !== ev.car || kind !== ev.kind || trk !== ev.trk || last !== ev.last)
        report($sformatf("got car %0d kind %0d track %0d last %0b, want %0d %s %0d %0b",
                         car, kind, trk, last, ev.car, ev.kind.name(), ev.trk, ev.last));
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;   // [7:0] car_number
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;   // [7:0] car_out
  logic [3:0]                    m_axis_tuser;   // [1:0] event_kind, [3:2] track_index
  logic                          m_axis_tlast;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rrht_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  railcar_board                  board;
  bit                            no_idle;
  bit                            hold_req;
  bit                            hold_done;
  int unsigned                   hold_left;
  int unsigned                   cycle_cnt;
  logic [rrht_pkg::CAR_W-1:0]    window_q [$];

  railcar_reorder_holding_tracks_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: random stalls, one long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left     <= LONG_HOLD;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.match_event(m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[3:2], m_axis_tlast);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // tvalid stays high after a transaction so back-to-back cars need no toggle
  task automatic send_car(input logic [rrht_pkg::CAR_W-1:0] car);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= car;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_car(car);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.due_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [rrht_pkg::PADDR_W-1:0] addr,
                           input logic [rrht_pkg::CAR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == FIRST_NUMBER_ADDR) board.load_first(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == FIRST_NUMBER_ADDR && prdata !== 32'(value))
      board.report($sformatf("first_number reads %0h, written %0h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // releases every parked car by restarting the count just below a track head
  task automatic clear_tracks();
    logic [rrht_pkg::CAR_W-1:0] h;
    while (board.held_cars() != 0) begin
      wait_idle();
      h = board.first_head();
      apb_write(FIRST_NUMBER_ADDR, h - 8'd1);
      send_car(h - 8'd1);
    end
    wait_idle();
  endtask

  // mostly shuffled runs of upcoming numbers, some noise
  task automatic run_random(input int base_idx);
    logic [rrht_pkg::CAR_W-1:0] car;
    logic [rrht_pkg::CAR_W-1:0] start;
    int                         n;
    int                         hits [$];
    window_q.delete();
    for (int i = 0; i < PHASE_CARS; i++) begin
      no_idle = (base_idx + i >= QUIET_FROM) && (base_idx + i < QUIET_TO);
      if (base_idx + i == HOLD_AT) hold_req = 1'b1;
      if (window_q.size() == 0) begin
        n = ($urandom_range(0, 9) == 0) ? 24 : $urandom_range(2, 10);
        start = board.next_car;
        for (int k = 0; k < n; k++) window_q.push_back(start + 8'(k));
      end
      if ($urandom_range(0, 9) == 0) car = 8'($urandom_range(0, 255));
      else car = window_q[$urandom_range(0, window_q.size() - 1)];
      if (board.would_fault(car)) car = board.next_car;
      hits = window_q.find_first_index(x) with (x == car);
      if (hits.size() != 0) window_q.delete(hits[0]);
      send_car(car);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    board         = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    hold_left     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of first_number, park and drain, then low and high cars parked
    foreach (OPENING_CARS[k]) send_car(OPENING_CARS[k]);
    wait_idle();
    // count wraps from 255 to 0 here
    clear_tracks();
    apb_write(SPARE_ADDR, 8'hff);
    apb_write(FIRST_NUMBER_ADDR, 8'd0);
    send_car(8'd2);
    send_car(8'd1);
    send_car(8'd0);
    // one track filled to depth, overflow to the next, then one long drain
    for (int k = 4; k <= 12; k++) send_car(8'(k));
    send_car(8'd3);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apb_write(FIRST_NUMBER_ADDR, 8'($urandom_range(0, 255)));
      run_random(p * PHASE_CARS);
      clear_tracks();
    end

    // block every track, then a car that fits none; the fault sticks
    apb_write(FIRST_NUMBER_ADDR, 8'd0);
    foreach (FAULT_CARS[k]) send_car(FAULT_CARS[k]);
    send_car(8'd0);
    send_car(8'($urandom_range(0, 255)));
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (board.due_events.size() != 0)
      board.report($sformatf("%0d results never arrived", board.due_events.size()));
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
